FILE: rtl/clsr_pkg.sv
package clsr_pkg;

	// Generator word and shuffle table geometry.
	localparam int GEN_W      = 31;
	localparam int TABLE_SIZE = 32;
	localparam int TBL_AW     = $clog2(TABLE_SIZE);
	localparam int WARMUP     = TABLE_SIZE + 8;
	localparam int CNT_W      = $clog2(WARMUP);

	// Multipliers are 16 bits, so one product is 47 bits wide.
	localparam int MUL_W  = 16;
	localparam int PROD_W = GEN_W + MUL_W;

	localparam logic [GEN_W-1:0] MOD1        = 31'd2147483563;
	localparam logic [GEN_W-1:0] MOD2        = 31'd2147483399;
	localparam logic [MUL_W-1:0] MUL1        = 16'd40014;
	localparam logic [MUL_W-1:0] MUL2        = 16'd40692;
	localparam logic [GEN_W-1:0] SECOND_SEED = 31'd123456789;

	// 2^31 is congruent to these values modulo MOD1 and MOD2.
	localparam int FOLD_W = 8;
	localparam logic [FOLD_W-1:0] FOLD1 = 8'd85;
	localparam logic [FOLD_W-1:0] FOLD2 = 8'd249;

	localparam logic [GEN_W-1:0] RANGE1   = MOD1 - 31'd1;
	localparam logic [GEN_W:0]   SLOT_DIV = 32'(1 + 2147483562 / TABLE_SIZE);
	localparam int               SLOT_SH  = GEN_W - TBL_AW;

	localparam int               FRAC_W   = 24;
	localparam int               FRAC_SH  = GEN_W - FRAC_W;
	localparam logic [FRAC_W-1:0] FRAC_MAX = 24'd16777214;

	// Stream word widths, padded to whole bytes.
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;

endpackage

FILE: rtl/clsr_ram.sv
module clsr_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/combined_lcg_shuffle_rng.sv
// Channel   Direction  tdata (low bit up)                    tuser
// s_*       in         seed[30:0], one zero pad bit          action (1 = reseed, then draw)
// m_*       out        value_int[30:0], fraction[54:31], pad  none
//
// A draw runs in steps: the multiply registers at the accepting edge, then come the modular
// fold, the table subtract and the output load. A reseed first runs a warm-up that fills the
// table, on the single first-generator multiply and fold unit.
// Reset loads the generator start values and clears the per-slot valid bits. A slot never
// written reads as zero, so there is no clearing pass. A stalled output holds the block in its
// last step. A new word is taken while an earlier result still waits in the output register.
module combined_lcg_shuffle_rng (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [clsr_pkg::IN_DATA_W-1:0]     s_tdata,  // seed[30:0], pad[31]
	input  logic                               s_tuser,  // action[0]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [clsr_pkg::OUT_DATA_W-1:0]    m_tdata   // value_int[30:0], fraction[54:31], pad[55]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMUL,
		ST_SRED,
		ST_DMUL,
		ST_RED,
		ST_DIFF,
		ST_OUT
	} state_t;

	function automatic logic [clsr_pkg::GEN_W-1:0] mod_fold(
		input logic [clsr_pkg::PROD_W-1:0] p,
		input logic [clsr_pkg::FOLD_W-1:0] k,
		input logic [clsr_pkg::GEN_W-1:0]  m
	);
		logic [clsr_pkg::GEN_W:0] t;
		// High part times (2^31 mod m) plus low part stays below twice the modulus.
		t = (clsr_pkg::GEN_W+1)'(p[clsr_pkg::GEN_W-1:0])
			+ (clsr_pkg::GEN_W+1)'(p[clsr_pkg::PROD_W-1:clsr_pkg::GEN_W])
			* (clsr_pkg::GEN_W+1)'(k);
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[clsr_pkg::GEN_W-1:0];
	endfunction

	function automatic logic [clsr_pkg::TBL_AW-1:0] slot_of(
		input logic [clsr_pkg::GEN_W-1:0] v
	);
		logic [clsr_pkg::TBL_AW:0]  q0;
		logic [clsr_pkg::TBL_AW:0]  q;
		logic [clsr_pkg::GEN_W:0]   bound;
		// The divisor is just below 2^26, so the shifted estimate is low by at most one.
		q0    = {1'b0, v[clsr_pkg::GEN_W-1:clsr_pkg::SLOT_SH]};
		bound = clsr_pkg::SLOT_DIV * (clsr_pkg::GEN_W+1)'(q0 + 1'b1);
		q     = ({1'b0, v} >= bound) ? q0 + 1'b1 : q0;
		if (q > (clsr_pkg::TBL_AW+1)'(clsr_pkg::TABLE_SIZE - 1)) begin
			q = (clsr_pkg::TBL_AW+1)'(clsr_pkg::TABLE_SIZE - 1);
		end
		return q[clsr_pkg::TBL_AW-1:0];
	endfunction

	function automatic logic [clsr_pkg::FRAC_W-1:0] frac_of(
		input logic [clsr_pkg::GEN_W-1:0] v
	);
		logic [clsr_pkg::FRAC_W-1:0] q0;
		logic [clsr_pkg::FRAC_W:0]   qp;
		logic [clsr_pkg::FRAC_W:0]   q;
		logic [clsr_pkg::GEN_W+1:0]  lhs;
		// v * 2^24 / MOD1 is v >> 7 or one more; the step up happens when
		// low7 * 2^24 + (q0 + 1) * 85 reaches 2^31.
		q0  = v[clsr_pkg::GEN_W-1:clsr_pkg::FRAC_SH];
		qp  = (clsr_pkg::FRAC_W+1)'(q0) + 1'b1;
		lhs = (clsr_pkg::GEN_W+2)'({v[clsr_pkg::FRAC_SH-1:0], {clsr_pkg::FRAC_W{1'b0}}})
			+ (clsr_pkg::GEN_W+2)'(qp) * (clsr_pkg::GEN_W+2)'(clsr_pkg::FOLD1);
		q   = (lhs >= ((clsr_pkg::GEN_W+2)'(1) << clsr_pkg::GEN_W)) ? qp : {1'b0, q0};
		if (q > {1'b0, clsr_pkg::FRAC_MAX}) begin
			q = {1'b0, clsr_pkg::FRAC_MAX};
		end
		return q[clsr_pkg::FRAC_W-1:0];
	endfunction

	state_t                          state_q;
	logic [clsr_pkg::GEN_W-1:0]      g1_q;
	logic [clsr_pkg::GEN_W-1:0]      g2_q;
	logic [clsr_pkg::GEN_W-1:0]      last_q;
	logic [clsr_pkg::CNT_W-1:0]      cnt_q;
	logic [clsr_pkg::TABLE_SIZE-1:0] valid_q;
	logic [clsr_pkg::PROD_W-1:0]     p1_s1;
	logic [clsr_pkg::PROD_W-1:0]     p2_s1;
	logic [clsr_pkg::TBL_AW-1:0]     slot_s1;
	logic [clsr_pkg::GEN_W-1:0]      entry_s2;
	logic                            out_val_q;
	logic [clsr_pkg::GEN_W-1:0]      out_int_q;
	logic [clsr_pkg::FRAC_W-1:0]     out_frac_q;

	logic                            in_acc;
	logic                            start_draw;
	logic                            warm_store;
	logic                            out_load;
	logic [clsr_pkg::GEN_W-1:0]      seed_eff;
	logic [clsr_pkg::GEN_W-1:0]      red1;
	logic [clsr_pkg::GEN_W-1:0]      red2;
	logic [clsr_pkg::GEN_W+1:0]      diff_raw;
	logic [clsr_pkg::GEN_W+1:0]      diff_wrap;
	logic [clsr_pkg::TBL_AW-1:0]     rd_slot;
	logic                            ram_we;
	logic [clsr_pkg::TBL_AW-1:0]     ram_waddr;
	logic [clsr_pkg::GEN_W-1:0]      ram_wdata;
	logic [clsr_pkg::GEN_W-1:0]      ram_rdata;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_acc     = s_tvalid && s_tready;
	assign start_draw = (in_acc && !s_tuser) || (state_q == ST_DMUL);
	assign warm_store = (state_q == ST_SRED) && (cnt_q < clsr_pkg::CNT_W'(clsr_pkg::TABLE_SIZE));
	assign out_load   = (state_q == ST_OUT) && (!out_val_q || m_tready);

	assign seed_eff = (s_tdata[clsr_pkg::GEN_W-1:0] == '0) ?
		clsr_pkg::GEN_W'(1) : s_tdata[clsr_pkg::GEN_W-1:0];

	assign red1    = mod_fold(p1_s1, clsr_pkg::FOLD1, clsr_pkg::MOD1);
	assign red2    = mod_fold(p2_s1, clsr_pkg::FOLD2, clsr_pkg::MOD2);
	assign rd_slot = slot_of(last_q);

	// Table entry minus the second generator, wrapped into 1..RANGE1.
	assign diff_raw  = (clsr_pkg::GEN_W+2)'(entry_s2) + (clsr_pkg::GEN_W+2)'(clsr_pkg::RANGE1)
		- (clsr_pkg::GEN_W+2)'(g2_q);
	assign diff_wrap = (diff_raw > (clsr_pkg::GEN_W+2)'(clsr_pkg::RANGE1)) ?
		diff_raw - (clsr_pkg::GEN_W+2)'(clsr_pkg::RANGE1) : diff_raw;

	// Only one item is in flight, so a write never races a read of the same slot.
	assign ram_we    = warm_store || (state_q == ST_DIFF);
	assign ram_waddr = (state_q == ST_DIFF) ? slot_s1 : cnt_q[clsr_pkg::TBL_AW-1:0];
	assign ram_wdata = (state_q == ST_DIFF) ? g1_q : red1;

	clsr_ram #(
		.WIDTH(clsr_pkg::GEN_W),
		.DEPTH(clsr_pkg::TABLE_SIZE)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_slot),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			g1_q       <= clsr_pkg::GEN_W'(1);
			g2_q       <= clsr_pkg::SECOND_SEED;
			last_q     <= '0;
			cnt_q      <= '0;
			valid_q    <= '0;
			p1_s1      <= '0;
			p2_s1      <= '0;
			slot_s1    <= '0;
			entry_s2   <= '0;
			out_val_q  <= 1'b0;
			out_int_q  <= '0;
			out_frac_q <= '0;
		end else begin
			if (out_load) begin
				out_val_q <= 1'b1;
			end else if (m_tready) begin
				out_val_q <= 1'b0;
			end
			if (start_draw) begin
				p1_s1   <= clsr_pkg::PROD_W'(g1_q) * clsr_pkg::PROD_W'(clsr_pkg::MUL1);
				p2_s1   <= clsr_pkg::PROD_W'(g2_q) * clsr_pkg::PROD_W'(clsr_pkg::MUL2);
				slot_s1 <= rd_slot;
				state_q <= ST_RED;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (in_acc) begin
							g1_q    <= seed_eff;
							g2_q    <= seed_eff;
							cnt_q   <= clsr_pkg::CNT_W'(clsr_pkg::WARMUP - 1);
							state_q <= ST_SMUL;
						end
					end
					ST_SMUL: begin
						p1_s1   <= clsr_pkg::PROD_W'(g1_q) * clsr_pkg::PROD_W'(clsr_pkg::MUL1);
						state_q <= ST_SRED;
					end
					ST_SRED: begin
						g1_q <= red1;
						if (warm_store) begin
							valid_q[cnt_q[clsr_pkg::TBL_AW-1:0]] <= 1'b1;
						end
						if (cnt_q == '0) begin
							// Slot zero was written last; it becomes the previous output.
							last_q  <= red1;
							state_q <= ST_DMUL;
						end else begin
							cnt_q   <= cnt_q - 1'b1;
							state_q <= ST_SMUL;
						end
					end
					ST_DMUL: begin
						state_q <= ST_RED;
					end
					ST_RED: begin
						g1_q     <= red1;
						g2_q     <= red2;
						entry_s2 <= valid_q[slot_s1] ? ram_rdata : '0;
						state_q  <= ST_DIFF;
					end
					ST_DIFF: begin
						last_q           <= diff_wrap[clsr_pkg::GEN_W-1:0];
						valid_q[slot_s1] <= 1'b1;
						state_q          <= ST_OUT;
					end
					ST_OUT: begin
						if (out_load) begin
							out_int_q  <= last_q;
							out_frac_q <= frac_of(last_q);
							state_q    <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_val_q;
	assign m_tdata  = {1'b0, out_frac_q, out_int_q};

`ifndef NO_ASSERTIONS
	a_draw_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser) |=> (state_q == ST_RED) ##1 (state_q == ST_DIFF))
		else $error("draw did not go through fold and subtract steps");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_val_q |-> (out_int_q != '0) && (out_int_q <= clsr_pkg::RANGE1))
		else $error("output integer out of range");

	a_frac_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_val_q |-> (out_frac_q <= clsr_pkg::FRAC_MAX))
		else $error("fraction above saturation limit");

	a_table_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DMUL) |-> (&valid_q))
		else $error("warm-up left table slots unwritten");
`endif

endmodule
